FILE: hdl/pa_pkg.sv
// Shared types and constants of the preferential attachment graph builder.
package pa_pkg;

    localparam int DEG_W      = 16;
    localparam int RAND_BITS  = 16;
    localparam int NODE_CNT_W = 11;
    localparam int LINKS_W    = 5;
    localparam int NODE_ID_W  = 10;
    localparam int CFG_ADDR_W = 3;

    localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 11'd10;
    localparam logic [LINKS_W-1:0]    LINKS_RST      = 5'd4;

    // register index, taken from paddr[2]
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_LINKS      = 1'b1;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [RAND_BITS-1:0] random_word;
    } in_item_t;

    typedef struct packed {
        logic                 edge_valid;
        logic [NODE_ID_W-1:0] new_node;
        logic [NODE_ID_W-1:0] target_node;
        logic                 done_res;
    } out_item_t;

endpackage

FILE: hdl/pa_deg_ram.sv
// Degree store: one write port, one registered read port.
module pa_deg_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [pa_pkg::DEG_W-1:0]   wdata,
    input  logic [AW-1:0]              raddr,
    output logic [pa_pkg::DEG_W-1:0]   rdata
);

    logic [pa_pkg::DEG_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/pa_acc_unit.sv
// Shared adder and compare unit: running degree sum and degree increments.
module pa_acc_unit (
    input  logic [pa_pkg::DEG_W:0]     a,
    input  logic [pa_pkg::DEG_W-1:0]   b,
    input  logic [pa_pkg::DEG_W-1:0]   limit,
    output logic [pa_pkg::DEG_W:0]     sum,
    output logic                       gt
);

    // sum never overflows: a stays at or below limit while walking
    assign sum = a + (pa_pkg::DEG_W+1)'(b);
    assign gt  = sum > (pa_pkg::DEG_W+1)'(limit);

endmodule

FILE: hdl/preferential_attachment_graph_builder_top.sv
// Top level: APB registers, sequencer, degree store and shared sum unit.
//
// Usage: write node_count (0x0) and links_per_node (0x4) over APB while idle.
// Raise start with an item when busy is low; the item is taken at that edge.
// A start item (kind 0) seeds a full core of c = min(m, n) nodes, one write
// per cycle; its all-zero result word shows after the last seed write.
// A draw item (kind 1) places one edge. Its result shows after these steps:
// one multiply for the pick value, then the cumulative degree walk reads one
// stored degree per cycle from the degree memory (registered read data), then
// two write steps bump the two endpoint degrees. A draw that is ignored (no
// start yet, graph done) answers in the cycle after it is taken.
// busy is high from the cycle after an item is taken until its result word is
// shown (never for an ignored draw); one item is worked on at a time.
// Each result word is shown for exactly one cycle; the receiver cannot stall.
// Reset clears the sequencer and the build state; the degree memory needs no
// clearing since every entry is written before the walk reads it.
module preferential_attachment_graph_builder_top #(
    parameter int MAX_NODES          = 1024,
    parameter int MAX_LINKS_PER_NODE = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pa_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  pa_pkg::in_item_t               item,
    output logic                           result_valid,
    output pa_pkg::out_item_t              result
);

    localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = ($clog2(MAX_NODES + 1) > pa_pkg::NODE_CNT_W)
                           ? $clog2(MAX_NODES + 1) : pa_pkg::NODE_CNT_W;
    localparam int ML_W  = ($clog2(MAX_LINKS_PER_NODE + 1) > pa_pkg::LINKS_W)
                           ? $clog2(MAX_LINKS_PER_NODE + 1) : pa_pkg::LINKS_W;
    localparam int DW    = pa_pkg::DEG_W;

    typedef enum logic [2:0] {
        IDLE_S,
        SEED_S,
        MUL_S,
        WALK_S,
        UPD_T_S,
        UPD_N_S
    } state_t;

    // configuration registers
    logic [pa_pkg::NODE_CNT_W-1:0] node_count_reg;
    logic [pa_pkg::LINKS_W-1:0]    links_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= pa_pkg::NODE_COUNT_RST;
            links_reg      <= pa_pkg::LINKS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                pa_pkg::REG_NODE_COUNT: node_count_reg <= pwdata[pa_pkg::NODE_CNT_W-1:0];
                pa_pkg::REG_LINKS:      links_reg      <= pwdata[pa_pkg::LINKS_W-1:0];
                default:                links_reg      <= links_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            pa_pkg::REG_NODE_COUNT: prdata = 32'(node_count_reg);
            pa_pkg::REG_LINKS:      prdata = 32'(links_reg);
            default:                prdata = '0;
        endcase
    end

    // effective n and m
    logic [CNT_W-1:0] n_eff;
    logic [ML_W-1:0]  m_eff;
    logic [CNT_W-1:0] m_ext;
    logic [CNT_W-1:0] core_c;

    always_comb
    begin
        if (CNT_W'(node_count_reg) > CNT_W'(MAX_NODES))
            n_eff = CNT_W'(MAX_NODES);
        else
            n_eff = CNT_W'(node_count_reg);

        if (links_reg == '0)
            m_eff = ML_W'(1);
        else if (ML_W'(links_reg) > ML_W'(MAX_LINKS_PER_NODE))
            m_eff = ML_W'(MAX_LINKS_PER_NODE);
        else
            m_eff = ML_W'(links_reg);

        m_ext  = CNT_W'(m_eff);
        core_c = (m_ext < n_eff) ? m_ext : n_eff;
    end

    // sequencer state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [ML_W-1:0]        core_reg, core_next;
    logic [DW:0]            cum_reg, cum_next;
    logic [DW-1:0]          pick_reg, pick_next;
    logic [DW-1:0]          esum_reg, esum_next;
    logic [pa_pkg::RAND_BITS-1:0] word_reg, word_next;
    logic [DW-1:0]          tdeg_reg, tdeg_next;
    logic [AW-1:0]          target_reg, target_next;
    logic [DW-1:0]          new_deg_reg, new_deg_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [DW-1:0]          total_reg, total_next;
    logic [CNT_W-1:0]       next_node_reg, next_node_next;
    logic [pa_pkg::LINKS_W-1:0] link_reg, link_next;
    logic                   finished_reg, finished_next;
    logic                   result_valid_reg, result_valid_next;
    pa_pkg::out_item_t      result_reg, result_next;

    // memory and shared unit
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [DW-1:0]          ram_wdata;
    logic [DW-1:0]          ram_rdata;
    logic [DW:0]            acc_a;
    logic [DW-1:0]          acc_b;
    logic [DW:0]            acc_sum;
    logic                   acc_gt;

    logic [2*DW-1:0]        prod;
    logic [2*ML_W-1:0]      core_sq;
    logic                   accept;
    logic                   issue;
    logic                   node_full;

    assign accept    = start && !busy;
    assign prod      = (2*DW)'(esum_reg) * (2*DW)'(word_reg);
    assign core_sq   = (2*ML_W)'(core_reg) * ((2*ML_W)'(core_reg) - 1'b1);
    assign issue     = j_reg < next_node_reg;
    assign node_full = ((ML_W+1)'(link_reg) + 1'b1) >= (ML_W+1)'(m_eff);

    pa_deg_ram #(
        .DEPTH (MAX_NODES),
        .AW    (AW)
    ) u_deg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (j_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    pa_acc_unit u_acc (
        .a     (acc_a),
        .b     (acc_b),
        .limit (pick_reg),
        .sum   (acc_sum),
        .gt    (acc_gt)
    );

    always_comb
    begin
        case (state_reg)
            UPD_T_S:
            begin
                acc_a = {1'b0, tdeg_reg};
                acc_b = DW'(1);
            end
            UPD_N_S:
            begin
                acc_a = {1'b0, new_deg_reg};
                acc_b = DW'(1);
            end
            default:
            begin
                acc_a = cum_reg;
                acc_b = ram_rdata;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        j_next            = j_reg;
        core_next         = core_reg;
        cum_next          = cum_reg;
        pick_next         = pick_reg;
        esum_next         = esum_reg;
        word_next         = word_reg;
        tdeg_next         = tdeg_reg;
        target_next       = target_reg;
        new_deg_next      = new_deg_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = j_reg;
        total_next        = total_reg;
        next_node_next    = next_node_reg;
        link_next         = link_reg;
        finished_next     = finished_reg;
        result_valid_next = 1'b0;
        result_next       = '0;
        ram_we            = 1'b0;
        ram_waddr         = target_reg;
        ram_wdata         = acc_sum[DW-1:0];

        case (state_reg)
            IDLE_S:
            begin
                if (accept)
                begin
                    word_next = item.random_word;
                    if (item.kind == pa_pkg::KIND_START)
                    begin
                        core_next  = ML_W'(core_c);
                        j_next     = '0;
                        state_next = SEED_S;
                    end
                    else if (finished_reg || next_node_reg == '0)
                    begin
                        result_valid_next = 1'b1;
                    end
                    else if (next_node_reg >= n_eff)
                    begin
                        finished_next     = 1'b1;
                        result_valid_next = 1'b1;
                    end
                    else
                    begin
                        if (link_reg == '0)
                            new_deg_next = '0;
                        esum_next  = total_reg - DW'(link_reg);
                        state_next = MUL_S;
                    end
                end
            end

            SEED_S:
            begin
                if (j_reg < CNT_W'(core_reg))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg[AW-1:0];
                    ram_wdata = DW'(core_reg) - 1'b1;
                    j_next    = j_reg + 1'b1;
                end
                else
                begin
                    total_next        = DW'(core_sq);
                    next_node_next    = CNT_W'(core_reg);
                    link_next         = '0;
                    finished_next     = CNT_W'(core_reg) >= n_eff;
                    result_valid_next = 1'b1;
                    state_next        = IDLE_S;
                end
            end

            MUL_S:
            begin
                pick_next  = prod[DW+pa_pkg::RAND_BITS-1:pa_pkg::RAND_BITS];
                j_next     = '0;
                cum_next   = '0;
                state_next = WALK_S;
            end

            WALK_S:
            begin
                // read issued at j_reg; its data is checked in the next cycle
                rd_vld_next = issue;
                if (issue)
                    j_next = j_reg + 1'b1;
                if (rd_vld_reg)
                begin
                    tdeg_next   = ram_rdata;
                    target_next = rd_idx_reg[AW-1:0];
                    cum_next    = acc_sum;
                    // zero degree sum falls through to the last existing node
                    if (acc_gt || rd_idx_reg == next_node_reg - 1'b1)
                    begin
                        rd_vld_next = 1'b0;
                        state_next  = UPD_T_S;
                    end
                end
            end

            UPD_T_S:
            begin
                ram_we     = 1'b1;
                ram_waddr  = target_reg;
                state_next = UPD_N_S;
            end

            UPD_N_S:
            begin
                ram_we                  = 1'b1;
                ram_waddr               = next_node_reg[AW-1:0];
                new_deg_next            = acc_sum[DW-1:0];
                total_next              = total_reg + DW'(2);
                result_valid_next       = 1'b1;
                result_next.edge_valid  = 1'b1;
                result_next.new_node    = pa_pkg::NODE_ID_W'(next_node_reg);
                result_next.target_node = pa_pkg::NODE_ID_W'(target_reg);
                if (node_full)
                begin
                    link_next      = '0;
                    next_node_next = next_node_reg + 1'b1;
                    if ((next_node_reg + 1'b1) >= n_eff)
                    begin
                        finished_next        = 1'b1;
                        result_next.done_res = 1'b1;
                    end
                end
                else
                begin
                    link_next = link_reg + 1'b1;
                end
                state_next = IDLE_S;
            end

            default:
            begin
                state_next = IDLE_S;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE_S;
            j_reg            <= '0;
            core_reg         <= '0;
            cum_reg          <= '0;
            pick_reg         <= '0;
            esum_reg         <= '0;
            word_reg         <= '0;
            tdeg_reg         <= '0;
            target_reg       <= '0;
            new_deg_reg      <= '0;
            rd_vld_reg       <= 1'b0;
            rd_idx_reg       <= '0;
            total_reg        <= '0;
            next_node_reg    <= '0;
            link_reg         <= '0;
            finished_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            j_reg            <= j_next;
            core_reg         <= core_next;
            cum_reg          <= cum_next;
            pick_reg         <= pick_next;
            esum_reg         <= esum_next;
            word_reg         <= word_next;
            tdeg_reg         <= tdeg_next;
            target_reg       <= target_next;
            new_deg_reg      <= new_deg_next;
            rd_vld_reg       <= rd_vld_next;
            rd_idx_reg       <= rd_idx_next;
            total_reg        <= total_next;
            next_node_reg    <= next_node_next;
            link_reg         <= link_next;
            finished_reg     <= finished_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign busy         = state_reg != IDLE_S;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || result_valid)
        else $error("taken item neither started work nor answered");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.edge_valid |->
            result.new_node == '0 && result.target_node == '0 && !result.done_res)
        else $error("result without an edge carries nonzero fields");

    a_target_before_new: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == UPD_N_S |-> CNT_W'(target_reg) < next_node_reg)
        else $error("edge target is not an existing node");

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg && state_reg != SEED_S |=> finished_reg)
        else $error("finished flag cleared outside of a core seed");
`endif

endmodule
